// ----- src/acds_pkg.sv -----
// Shared types and constants for the anchor chain scoring engine.
// No dependencies; imported by the top level, the window store, the pair unit and the testbench.
package acds_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TOT_W     = 48;

  localparam logic [63:0] LOG_C1_Q30 = 64'd370278182;
  localparam logic [63:0] LOG_C2_Q30 = 64'd2173968328;
  localparam logic [63:0] LOG_C3_Q30 = 64'd724644294;
  localparam logic [63:0] LOG_C1 =
    (LOG_C1_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic [63:0] LOG_C2 =
    (LOG_C2_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic [63:0] LOG_C3 =
    (LOG_C3_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  localparam logic [7:0]  SPAN_MASK = 8'hff;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SCORE_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    REG_MAX_DIST_REF   = 3'd0,
    REG_MAX_DIST_QUERY = 3'd1,
    REG_BAND_WIDTH     = 3'd2,
    REG_MAX_PRED       = 3'd3,
    REG_GAP_PENALTY    = 3'd4,
    REG_SKIP_PENALTY   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] max_dist_ref;
    logic [30:0] max_dist_query;
    logic [30:0] band_width;
    logic [23:0] gap_penalty;
    logic [23:0] skip_penalty;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        key;
    logic [31:0]        pos;
    logic [31:0]        qry;
    logic [7:0]         span;
    logic signed [31:0] score;
    logic signed [31:0] peak;
  } slot_t;

  typedef struct packed {
    logic                    done;
    logic                    hit;
    logic signed [TOT_W-1:0] total;
  } pu_rsp_t;

  typedef enum logic [2:0] {
    PU_IDLE, PU_DIFF, PU_MGAP, PU_MSKIP, PU_LOGN, PU_MC1, PU_MT1, PU_FIN
  } pu_state_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WS_RD, ST_WS_CHK, ST_CAP, ST_SC_RD, ST_SC_CHK, ST_SC_WAIT,
    ST_BT, ST_BT_WAIT, ST_RES
  } state_t;

  function automatic logic signed [31:0] sat_score(input logic signed [TOT_W-1:0] v);
    if (v > TOT_W'(SCORE_MAX)) sat_score = SCORE_MAX;
    else sat_score = v[31:0];
  endfunction

endpackage

// ----- src/anchor_chain_dp_scorer_unit.sv -----
// Top level of the anchor chain scoring engine: sequencer, window store,
// best-anchor tracking and register port. Depends on acds_pkg,
// acds_win_mem and acds_pair_unit.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | in_start_set .. in_seed_span   | in_valid / in_ready
//  result  | out_chain_score .. peak_score  | out_valid / out_ready
//  config  | psel penable pwrite paddr ...  | APB write, pready tied high
//
// Per anchor, W window entries are first dropped from the front, then P predecessors
// are scanned (P <= max_predecessors), each scored by the shared multiplier unit,
// plus the best anchor. in_ready is high only between transactions. A stalled
// result keeps the engine in its final step, so the next anchor waits. Reset is
// synchronous; the window store has none.
module anchor_chain_dp_scorer_unit #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_start_set,
  input  logic [31:0]        in_ref_key,
  input  logic [31:0]        in_ref_pos,
  input  logic signed [31:0] in_query_pos,
  input  logic [7:0]         in_seed_span,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_chain_score,
  output logic signed [31:0] out_pred_index,
  output logic signed [31:0] out_peak_score,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import acds_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_DEPTH - 1);
  localparam logic [31:0]   CAP_MAX   = 32'(WINDOW_DEPTH - 1);

  cfg_t        cfg_r;
  logic [9:0]  max_pred_r;
  state_t      state_r, state_nxt;

  slot_t       cur_r, best_r, mem_rd, mem_wd;
  logic [31:0] i_r, st_r, scan_idx_r, best_idx_r, pred_r;
  logic [AW-1:0] i_addr_r, st_addr_r, scan_addr_r, rem_r, span_len_r, mem_ra;
  logic        best_valid_r, rescan_r, has_pred_r;
  logic signed [31:0] mx_r, pred_peak_r;
  logic signed [TOT_W-1:0] max_f_r;
  logic        out_valid_r;
  logic signed [31:0] out_score_r, out_pred_r, out_peak_r;
  logic signed [31:0] u_peak_hold;

  logic        pu_start, use_best, mem_we, ws_skip, bt_try, res_go, best_take;
  slot_t       pu_slot;
  pu_rsp_t     pu_rsp;
  logic [31:0] cap32, diff32;
  logic [AW:0] cap_addr;
  logic [63:0] xdist;
  logic signed [31:0] res_peak;

  // ---------------- register port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_dist_ref   <= 31'd5000;
      cfg_r.max_dist_query <= 31'd5000;
      cfg_r.band_width     <= 31'd500;
      max_pred_r           <= 10'd1023;
      cfg_r.gap_penalty    <= 24'd7864;
      cfg_r.skip_penalty   <= 24'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_MAX_DIST_REF:   cfg_r.max_dist_ref   <= pwdata[30:0];
        REG_MAX_DIST_QUERY: cfg_r.max_dist_query <= pwdata[30:0];
        REG_BAND_WIDTH:     cfg_r.band_width     <= pwdata[30:0];
        REG_MAX_PRED:       max_pred_r           <= pwdata[9:0];
        REG_GAP_PENALTY:    cfg_r.gap_penalty    <= pwdata[23:0];
        REG_SKIP_PENALTY:   cfg_r.skip_penalty   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_MAX_DIST_REF:   prdata = {1'b0, cfg_r.max_dist_ref};
      REG_MAX_DIST_QUERY: prdata = {1'b0, cfg_r.max_dist_query};
      REG_BAND_WIDTH:     prdata = {1'b0, cfg_r.band_width};
      REG_MAX_PRED:       prdata = {22'd0, max_pred_r};
      REG_GAP_PENALTY:    prdata = {8'd0, cfg_r.gap_penalty};
      REG_SKIP_PENALTY:   prdata = {8'd0, cfg_r.skip_penalty};
      default:            prdata = '0;
    endcase
  end

  // ---------------- submodules ----------------
  acds_win_mem #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_mem (
    .clk (clk),
    .we  (mem_we),
    .wa  (i_addr_r),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  acds_pair_unit u_pair (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (pu_start),
    .cfg     (cfg_r),
    .cur_pos (cur_r.pos),
    .cur_qry (cur_r.qry),
    .slot    (pu_slot),
    .rsp     (pu_rsp)
  );

  // ---------------- shared decode ----------------
  always_comb begin
    ws_skip = (mem_rd.key != cur_r.key)
              || ({1'b0, cur_r.pos} > ({1'b0, mem_rd.pos} + {2'b0, cfg_r.max_dist_ref}));
    cap32   = (32'(max_pred_r) > CAP_MAX) ? CAP_MAX : 32'(max_pred_r);
    diff32  = i_r - st_r;
    cap_addr = {1'b0, i_addr_r} - {1'b0, cap32[AW-1:0]};
    if (cap_addr[AW]) cap_addr = cap_addr + (AW + 1)'(WINDOW_DEPTH);
    xdist   = {cur_r.key, cur_r.pos} - {best_r.key, best_r.pos};
    bt_try  = best_valid_r && ((i_r - best_idx_r) > (32'(span_len_r) + 32'd1));
    res_go  = !out_valid_r || out_ready;
    res_peak = (has_pred_r && (pred_peak_r > max_f_r[31:0])) ? pred_peak_r
                                                            : max_f_r[31:0];
    best_take = !best_valid_r || ((xdist <= {33'd0, cfg_r.max_dist_ref})
                                  && (best_r.score < max_f_r[31:0]));
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_WS_RD;
      ST_WS_RD:   state_nxt = (st_r == i_r) ? ST_CAP : ST_WS_CHK;
      ST_WS_CHK:  state_nxt = ws_skip ? ST_WS_RD : ST_CAP;
      ST_CAP: begin
        if ((diff32 > cap32) ? (cap32 == '0) : (diff32 == '0)) state_nxt = ST_BT;
        else state_nxt = ST_SC_RD;
      end
      ST_SC_RD:   state_nxt = ST_SC_CHK;
      ST_SC_CHK:  state_nxt = ST_SC_WAIT;
      ST_SC_WAIT: begin
        if (pu_rsp.done) state_nxt = (rem_r == AW'(1)) ? ST_BT : ST_SC_RD;
      end
      ST_BT:      state_nxt = bt_try ? ST_BT_WAIT : ST_RES;
      ST_BT_WAIT: if (pu_rsp.done) state_nxt = ST_RES;
      ST_RES:     if (res_go) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_ready = 1'b0;
    pu_start = 1'b0;
    use_best = 1'b0;
    mem_we   = 1'b0;
    mem_ra   = st_addr_r;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_WS_RD:  mem_ra = st_addr_r;
      ST_SC_RD:  mem_ra = scan_addr_r;
      ST_SC_CHK: pu_start = 1'b1;
      ST_BT: begin
        pu_start = bt_try;
        use_best = 1'b1;
      end
      ST_RES:    mem_we = res_go;
      default: ;
    endcase
    pu_slot = use_best ? best_r : mem_rd;
    mem_wd  = cur_r;
    mem_wd.score = max_f_r[31:0];
    mem_wd.peak  = res_peak;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      i_r          <= '0;
      st_r         <= '0;
      i_addr_r     <= '0;
      st_addr_r    <= '0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      best_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_RES) && res_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_start_set) begin
            i_r          <= '0;
            st_r         <= '0;
            i_addr_r     <= '0;
            st_addr_r    <= '0;
            best_valid_r <= 1'b0;
          end
        end
        ST_WS_CHK: begin
          if (ws_skip) begin
            st_r      <= st_r + 32'd1;
            st_addr_r <= (st_addr_r == ADDR_LAST) ? '0 : st_addr_r + AW'(1);
          end
        end
        ST_CAP: begin
          if (diff32 > cap32) begin
            st_r      <= i_r - cap32;
            st_addr_r <= cap_addr[AW-1:0];
          end
          if (!best_valid_r || (xdist > {33'd0, cfg_r.max_dist_ref})) begin
            best_valid_r <= 1'b0;
          end
        end
        ST_SC_CHK: begin
          if (rescan_r && (mx_r < mem_rd.score)) begin
            best_valid_r <= 1'b1;
            best_idx_r   <= scan_idx_r;
            best_r       <= mem_rd;
          end
        end
        ST_RES: begin
          if (res_go) begin
            if (best_take) begin
              best_valid_r <= 1'b1;
              best_idx_r   <= i_r;
              best_r       <= mem_wd;
            end
            i_r      <= i_r + 32'd1;
            i_addr_r <= (i_addr_r == ADDR_LAST) ? '0 : i_addr_r + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cur_r.key   <= in_ref_key;
        cur_r.pos   <= in_ref_pos;
        cur_r.qry   <= in_query_pos;
        cur_r.span  <= in_seed_span & SPAN_MASK;
        cur_r.score <= '0;
        cur_r.peak  <= '0;
        max_f_r     <= TOT_W'(in_seed_span);
        has_pred_r  <= 1'b0;
        pred_peak_r <= '0;
        pred_r      <= '0;
      end
      ST_CAP: begin
        span_len_r  <= (diff32 > cap32) ? cap32[AW-1:0] : diff32[AW-1:0];
        rem_r       <= (diff32 > cap32) ? cap32[AW-1:0] : diff32[AW-1:0];
        scan_addr_r <= (i_addr_r == '0) ? ADDR_LAST : i_addr_r - AW'(1);
        scan_idx_r  <= i_r - 32'd1;
        rescan_r    <= !best_valid_r || (xdist > {33'd0, cfg_r.max_dist_ref});
        mx_r        <= SCORE_MIN;
      end
      ST_SC_CHK: begin
        if (rescan_r && (mx_r < mem_rd.score)) mx_r <= mem_rd.score;
      end
      ST_SC_WAIT: begin
        if (pu_rsp.done) begin
          if (pu_rsp.hit && (pu_rsp.total > max_f_r)) begin
            max_f_r     <= TOT_W'(sat_score(pu_rsp.total));
            has_pred_r  <= 1'b1;
            pred_r      <= scan_idx_r;
            pred_peak_r <= u_peak_hold;
          end
          rem_r       <= rem_r - AW'(1);
          scan_idx_r  <= scan_idx_r - 32'd1;
          scan_addr_r <= (scan_addr_r == '0) ? ADDR_LAST : scan_addr_r - AW'(1);
        end
      end
      ST_BT_WAIT: begin
        if (pu_rsp.done && pu_rsp.hit && (max_f_r < pu_rsp.total)) begin
          max_f_r     <= TOT_W'(sat_score(pu_rsp.total));
          has_pred_r  <= 1'b1;
          pred_r      <= best_idx_r;
          pred_peak_r <= best_r.peak;
        end
      end
      ST_RES: begin
        if (res_go) begin
          out_score_r <= max_f_r[31:0];
          out_pred_r  <= has_pred_r ? pred_r : 32'hffffffff;
          out_peak_r  <= res_peak;
        end
      end
      default: ;
    endcase
  end

  // peak of the slot under scoring, held while the pair unit runs
  always_ff @(posedge clk) begin
    if (state_r == ST_SC_CHK) u_peak_hold <= mem_rd.peak;
  end

  assign out_valid       = out_valid_r;
  assign out_chain_score = out_score_r;
  assign out_pred_index  = out_pred_r;
  assign out_peak_score  = out_peak_r;

endmodule

// ----- src/acds_win_mem.sv -----
// Window anchor store: one write port, one registered read port.
// Depends on acds_pkg for the slot type.
module acds_win_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  acds_pkg::slot_t  wd,
  input  logic [AW-1:0]    ra,
  output acds_pkg::slot_t  rd
);
  import acds_pkg::*;

  slot_t mem [DEPTH];
  slot_t rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

// ----- src/acds_pair_unit.sv -----
// Shared pair scoring unit: gap, skip and log penalty on one multiplier.
// Depends on acds_pkg; used by the top level for window and best anchors.
module acds_pair_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  acds_pkg::cfg_t    cfg,
  input  logic [31:0]       cur_pos,
  input  logic [31:0]       cur_qry,
  input  acds_pkg::slot_t   slot,
  output acds_pkg::pu_rsp_t rsp
);
  import acds_pkg::*;

  pu_state_t state_r, state_nxt;
  logic [31:0]        pos_i_r, qry_i_r, pos_j_r, qry_j_r;
  logic [7:0]         span_r;
  logic signed [31:0] score_r;
  logic [31:0]        dd_r;
  logic signed [32:0] dg_r;
  logic               ok_r, pen_en_r;
  logic signed [63:0] acc_r;
  logic [4:0]         e_r;
  logic [FRAC_BITS:0] m_r;
  logic signed [33:0] t1_r;
  pu_rsp_t            rsp_r;

  logic signed [32:0] dq;
  logic signed [31:0] dr;
  logic signed [33:0] ddiff, dd_abs;
  logic signed [32:0] dg, span_s;
  logic               ok;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod, prod_sh;
  logic [31:0]        lx;
  logic [4:0]         le;
  logic [31+FRAC_BITS:0] lsh;
  logic signed [63:0] pen;
  logic signed [TOT_W-1:0] sc;
  logic signed [32:0] scb;

  always_comb begin
    dq     = $signed({qry_i_r[31], qry_i_r}) - $signed({qry_j_r[31], qry_j_r});
    dr     = $signed(pos_i_r - pos_j_r);
    ddiff  = $signed({{2{dr[31]}}, dr}) - $signed({dq[32], dq});
    dd_abs = (ddiff < 0) ? -ddiff : ddiff;
    dg     = ($signed({dr[31], dr}) < dq) ? $signed({dr[31], dr}) : dq;
    span_s = $signed({25'd0, span_r});
    ok     = (dq > 0) && (dq <= $signed({2'b0, cfg.max_dist_ref}))
             && (dq <= $signed({2'b0, cfg.max_dist_query})) && (dr != 0)
             && (dd_abs <= $signed({3'b0, cfg.band_width}));
  end

  always_comb begin
    case (state_r)
      PU_MGAP: begin
        mul_a = $signed({10'd0, cfg.gap_penalty});
        mul_b = $signed({2'b0, dd_r});
      end
      PU_MSKIP: begin
        mul_a = $signed({10'd0, cfg.skip_penalty});
        mul_b = $signed({dg_r[32], dg_r});
      end
      PU_MC1: begin
        mul_a = $signed(LOG_C1[33:0]);
        mul_b = $signed({(33 - FRAC_BITS)'(0), m_r});
      end
      PU_MT1: begin
        mul_a = t1_r;
        mul_b = $signed({(33 - FRAC_BITS)'(0), m_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod    = mul_a * mul_b;
    prod_sh = prod >>> FRAC_BITS;
  end

  always_comb begin
    lx = dd_r + 32'd1;
    le = '0;
    for (int k = 0; k < 32; k++) begin
      if (lx[k]) le = 5'(k);
    end
    lsh = {lx, FRAC_BITS'(0)} >> le;
  end

  always_comb begin
    pen = acc_r >>> (FRAC_BITS + 1);
    scb = (dg_r < span_s) ? dg_r : span_s;
    sc  = pen_en_r ? (TOT_W'(scb) - pen[TOT_W-1:0]) : TOT_W'(scb);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PU_IDLE:  if (start) state_nxt = PU_DIFF;
      PU_DIFF:  state_nxt = ok ? PU_MGAP : PU_FIN;
      PU_MGAP:  state_nxt = PU_MSKIP;
      PU_MSKIP: state_nxt = (dd_r == '0) ? PU_FIN : PU_LOGN;
      PU_LOGN:  state_nxt = PU_MC1;
      PU_MC1:   state_nxt = PU_MT1;
      PU_MT1:   state_nxt = PU_FIN;
      PU_FIN:   state_nxt = PU_IDLE;
      default:  state_nxt = PU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PU_IDLE;
      rsp_r.done <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rsp_r.done <= (state_r == PU_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      PU_IDLE: begin
        pos_i_r <= cur_pos;
        qry_i_r <= cur_qry;
        pos_j_r <= slot.pos;
        qry_j_r <= slot.qry;
        span_r  <= slot.span;
        score_r <= slot.score;
      end
      PU_DIFF: begin
        ok_r     <= ok;
        dd_r     <= dd_abs[31:0];
        dg_r     <= dg;
        pen_en_r <= (dd_abs != 0) || (dg > span_s);
      end
      PU_MGAP:  acc_r <= $signed({prod[62:0], 1'b0});
      PU_MSKIP: acc_r <= acc_r + $signed({prod[62:0], 1'b0});
      PU_LOGN: begin
        e_r <= le;
        m_r <= lsh[FRAC_BITS:0];
      end
      PU_MC1:   t1_r <= $signed(LOG_C2[33:0]) - prod_sh[33:0];
      PU_MT1:   acc_r <= acc_r + ((64'(e_r) - 64'd1) <<< FRAC_BITS)
                         + prod_sh[63:0] - $signed(LOG_C3);
      PU_FIN: begin
        rsp_r.hit   <= ok_r;
        rsp_r.total <= sc + TOT_W'(score_r);
      end
      default: ;
    endcase
  end

  assign rsp = rsp_r;

endmodule

// ----- src/acds_checker.sv -----
// Port-level checks for the anchor chain scoring engine, bound to the top.
// Depends only on the top level's ports.
module acds_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_chain_score,
  input logic signed [31:0] out_pred_index,
  input logic signed [31:0] out_peak_score
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_chain_score)))
    else $error("stalled result changed");

  a_peak_ge_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_peak_score >= out_chain_score))
    else $error("peak below chain score");

  a_no_pred_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_pred_index == -32'sd1)) |-> (out_peak_score == out_chain_score))
    else $error("peak differs without predecessor");

  a_score_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_chain_score[31])
    else $error("negative chain score");

endmodule

bind anchor_chain_dp_scorer_unit acds_checker u_acds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_chain_score (out_chain_score),
  .out_pred_index  (out_pred_index),
  .out_peak_score  (out_peak_score)
);

// ----- bench/anchor_chain_dp_scorer_unit_tb.sv -----
// Testbench for anchor_chain_dp_scorer_unit: directed and random anchor sets,
// checked against an in-bench chaining-score predictor. Depends on acds_pkg.
`timescale 1ns / 100ps

module anchor_chain_dp_scorer_unit_tb;
  import acds_pkg::*;

  localparam int DEPTH = 1024;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    bit [31:0] key;
    bit [31:0] pos;
    bit [31:0] qry;
    bit [7:0]  span;
    int        score;
    int        peak;
  } anchor_t;

  typedef struct {
    int score;
    int pred;
    int peak;
  } chain_res_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic               in_start_set = 0;
  logic [31:0]        in_ref_key = 0;
  logic [31:0]        in_ref_pos = 0;
  logic signed [31:0] in_query_pos = 0;
  logic [7:0]         in_seed_span = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] out_chain_score;
  logic signed [31:0] out_pred_index;
  logic signed [31:0] out_peak_score;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [4:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  anchor_chain_dp_scorer_unit dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  bit [30:0] c_mdr = 5000, c_mdq = 5000, c_bw = 500;
  bit [9:0]  c_mp = 1023;
  bit [23:0] c_gap = 7864, c_skip = 0;
  anchor_t   win [DEPTH];
  bit [31:0] anchor_idx = 0, win_start = 0;
  longint    best_idx = -1;
  anchor_t   best_cp;

  chain_res_t expected_chains[$];
  int  errors = 0;
  int  n_sent = 0, n_checked = 0;
  int  snd_idle_pct = 0, rcv_idle_pct = 0;
  int  hold_cycles = 0;
  longint cycles = 0;

  // set generator state
  int        set_left = 0;
  bit [31:0] g_key, g_pos, g_qry;

  function automatic longint unsigned log2_q(longint unsigned x);
    int e;
    longint unsigned t, m, t1, t2;
    e = 0;
    t = x;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    m = (x << FRAC_BITS) >> e;
    t1 = LOG_C2 - ((LOG_C1 * m) >> FRAC_BITS);
    t2 = ((t1 * m) >> FRAC_BITS) - LOG_C3;
    return (longint'(e - 1) << FRAC_BITS) + t2;
  endfunction

  function automatic bit link_score(anchor_t ai, anchor_t aj, output longint sc);
    int qi, qj, d32;
    longint dq, dr, dd, dg, span, s, pen, den, mdr, mdq, bw, g, k;
    qi = ai.qry;
    qj = aj.qry;
    mdr = c_mdr;
    mdq = c_mdq;
    bw = c_bw;
    g = c_gap;
    k = c_skip;
    span = aj.span;
    sc = 0;
    dq = longint'(qi) - longint'(qj);
    if (dq <= 0 || dq > mdr || dq > mdq) return 0;
    d32 = ai.pos - aj.pos;
    dr = d32;
    if (dr == 0) return 0;
    dd = dr > dq ? dr - dq : dq - dr;
    if (dd > bw) return 0;
    dg = dr < dq ? dr : dq;
    sc = span < dg ? span : dg;
    if (dd != 0 || dg > span) begin
      s = 2 * (g * dd + k * dg);
      den = longint'(1) << (FRAC_BITS + 1);
      if (dd >= 1) s += longint'(log2_q(dd + 1));
      if (s >= 0) pen = s / den;
      else pen = -((-s + den - 1) / den);
      sc -= pen;
    end
    return 1;
  endfunction

  function automatic int clip_score(longint v);
    return v > 64'sd2147483647 ? 32'sh7fffffff : int'(v);
  endfunction

  function automatic longint unsigned xcoord(anchor_t a);
    return {a.key, a.pos};
  endfunction

  task automatic predict_chain(input bit start, input anchor_t cur);
    bit [31:0] i, st, cap, span_len, age, pred;
    longint    max_f, sc, mdr;
    int        pred_peak, mx;
    bit        has_pred;
    anchor_t   s;
    longint unsigned xi;
    chain_res_t r;
    pred = 0;
    pred_peak = 0;
    has_pred = 0;
    mdr = c_mdr;
    if (start) begin
      anchor_idx = 0;
      win_start = 0;
      best_idx = -1;
    end
    xi = xcoord(cur);
    i = anchor_idx;
    st = win_start;
    cap = c_mp > DEPTH - 1 ? DEPTH - 1 : c_mp;
    while (st != i) begin
      s = win[st % DEPTH];
      if (s.key != cur.key || longint'(cur.pos) > longint'(s.pos) + mdr) st++;
      else break;
    end
    if (i - st > cap) st = i - cap;
    span_len = i - st;
    max_f = cur.span;
    for (age = 1; age <= span_len; age++) begin
      s = win[(i - age) % DEPTH];
      if (link_score(cur, s, sc) && sc + s.score > max_f) begin
        max_f = clip_score(sc + s.score);
        has_pred = 1;
        pred = i - age;
        pred_peak = s.peak;
      end
    end
    if (best_idx < 0 || xi - xcoord(best_cp) > longint'(mdr)) begin
      mx = 32'sh80000000;
      best_idx = -1;
      for (age = 1; age <= span_len; age++) begin
        s = win[(i - age) % DEPTH];
        if (mx < s.score) begin
          mx = s.score;
          best_idx = longint'(i - age);
          best_cp = s;
        end
      end
    end
    if (best_idx >= 0 && (i - 32'(best_idx)) > span_len + 1) begin
      if (link_score(cur, best_cp, sc) && max_f < sc + best_cp.score) begin
        max_f = clip_score(sc + best_cp.score);
        has_pred = 1;
        pred = 32'(best_idx);
        pred_peak = best_cp.peak;
      end
    end
    cur.score = int'(max_f);
    cur.peak = (has_pred && pred_peak > cur.score) ? pred_peak : cur.score;
    win[i % DEPTH] = cur;
    if (best_idx < 0 ||
        (xi - xcoord(best_cp) <= longint'(mdr) && best_cp.score < cur.score)) begin
      best_idx = longint'(i);
      best_cp = cur;
    end
    anchor_idx = i + 1;
    win_start = st;
    r.score = cur.score;
    r.pred = has_pred ? int'(pred) : -1;
    r.peak = cur.peak;
    expected_chains.push_back(r);
  endtask

  // sampling at the falling edge: a handshake seen here completes at the next rise
  always @(negedge clk) begin
    anchor_t a;
    chain_res_t e;
    if (rst_n && in_valid && in_ready) begin
      a.key = in_ref_key;
      a.pos = in_ref_pos;
      a.qry = in_query_pos;
      a.span = in_seed_span;
      a.score = 0;
      a.peak = 0;
      predict_chain(in_start_set, a);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_chains.size() == 0) begin
        $error("result transaction with no expectation pending");
        errors++;
      end else begin
        e = expected_chains.pop_front();
        n_checked++;
        if (out_chain_score !== e.score) begin
          $error("chain_score exp %0d got %0d", e.score, out_chain_score);
          errors++;
        end
        if (out_pred_index !== e.pred) begin
          $error("pred_index exp %0d got %0d", e.pred, out_pred_index);
          errors++;
        end
        if (out_peak_score !== e.peak) begin
          $error("peak_score exp %0d got %0d", e.peak, out_peak_score);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_anchor(input bit start, input bit [31:0] key, input bit [31:0] pos,
                             input bit [31:0] qry, input bit [7:0] span);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_start_set <= start;
    in_ref_key <= key;
    in_ref_pos <= pos;
    in_query_pos <= qry;
    in_seed_span <= span;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (expected_chains.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input bit [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
    case (idx)
      REG_MAX_DIST_REF:   c_mdr = val[30:0];
      REG_MAX_DIST_QUERY: c_mdq = val[30:0];
      REG_BAND_WIDTH:     c_bw = val[30:0];
      REG_MAX_PRED:       c_mp = val[9:0];
      REG_GAP_PENALTY:    c_gap = val[23:0];
      REG_SKIP_PENALTY:   c_skip = val[23:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(input bit [31:0] mdr, mdq, bw, mp, gap, skip);
    wait_drained();
    cfg_write(REG_MAX_DIST_REF, mdr);
    cfg_write(REG_MAX_DIST_QUERY, mdq);
    cfg_write(REG_BAND_WIDTH, bw);
    cfg_write(REG_MAX_PRED, mp);
    cfg_write(REG_GAP_PENALTY, gap);
    cfg_write(REG_SKIP_PENALTY, skip);
  endtask

  // mostly sorted sets with small steps; the rest are raw random anchors
  task automatic send_random(input int n);
    bit start;
    repeat (n) begin
      start = 0;
      if (set_left == 0) begin
        set_left = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
        start = 1;
        g_key = $urandom_range(3) == 0 ? $urandom : $urandom_range(7);
        g_pos = $urandom;
        g_qry = $urandom;
      end
      set_left--;
      if ($urandom_range(99) < 15) begin
        send_anchor(start | ($urandom_range(15) == 0), $urandom, $urandom, $urandom,
                    $urandom_range(255));
      end else begin
        if ($urandom_range(19) == 0) g_key++;
        g_pos += $urandom_range(3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 600);
        g_qry += $urandom_range(9) == 0 ? -$urandom_range(0, 50) : $urandom_range(0, 600);
        send_anchor(start, g_key, g_pos, g_qry, $urandom_range(255));
      end
    end
  endtask

  task automatic test_directed();
    send_anchor(1, 5, 1000, 100, 0);
    send_anchor(0, 5, 1020, 120, 255);
    send_anchor(0, 5, 1040, 140, 20);
    send_anchor(0, 5, 1040, 150, 30);
    send_anchor(0, 5, 1060, 140, 40);
    send_anchor(0, 5, 1100, 170, 30);
    send_anchor(0, 5, 1130, 200, 30);
    send_anchor(0, 5, 1160, 230, 30);
    send_anchor(0, 6, 1200, 300, 60);
    send_anchor(0, 6, 9000, 8000, 10);
    send_anchor(0, 6, 9010, 8010, 10);
    send_anchor(0, 6, 32'hffffffff, 32'h7fffffff, 255);
    send_anchor(1, 32'hffffffff, 0, 32'h80000000, 0);
    send_anchor(0, 32'hffffffff, 100, 32'h80000064, 255);
    send_anchor(0, 32'hffffffff, 32'h80000000, 32'h00000000, 128);
    send_anchor(1, 0, 0, 0, 255);
    send_anchor(0, 0, 50, 50, 255);
    send_anchor(0, 0, 100, 100, 255);
  endtask

  task automatic test_config_sweep();
    cfg_all(0, 0, 0, 0, 0, 0);
    send_random(40);
    cfg_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1023, 24'hffffff, 24'hffffff);
    send_random(60);
    cfg_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 5, 0, 24'hffffff);
    send_random(60);
    cfg_all(2000, 3000, 200, 3, 3000, 500);
    send_random(60);
    cfg_all(5000, 5000, 500, 1023, 7864, 0);
  endtask

  task automatic test_idle_mix();
    snd_idle_pct = 37;
    rcv_idle_pct = 45;
    send_random(110);
    snd_idle_pct = 45;
    rcv_idle_pct = 37;
    send_random(110);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_random(100);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 3000;
    send_random(20);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_idle_mix();
    test_backpressure();
    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d anchors, %0d results checked, register extremes and stalls.",
             n_sent, n_checked);
    if (errors == 0 && expected_chains.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- anchor_chain_dp_scorer_unit.f -----
src/acds_pkg.sv
src/acds_win_mem.sv
src/acds_pair_unit.sv
src/anchor_chain_dp_scorer_unit.sv
src/acds_checker.sv
bench/anchor_chain_dp_scorer_unit_tb.sv
